// ----- src/mgrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrc_pkg
// shared constants, types and helpers of the grid route checker
// ----------------------------------------------------------------------------
package mgrc_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_AGENTS = 8;
    localparam int MAX_BASES  = 16;

    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int AG_W       = $clog2(MAX_AGENTS);
    localparam int SLOT_IDX_W = $clog2(MAX_BASES);
    localparam int OBS_AW     = ROW_W + COL_W;

    // register and field widths
    localparam int DIM_W      = 7;
    localparam int CNT_W      = 4;
    localparam int SLOT_W     = 4;
    localparam int ID_W       = 8;
    localparam int DIR_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_COUNT = 2'd2;

    localparam logic [DIR_W-1:0] DIR_N    = 4'd0;
    localparam logic [DIR_W-1:0] DIR_NE   = 4'd1;
    localparam logic [DIR_W-1:0] DIR_E    = 4'd2;
    localparam logic [DIR_W-1:0] DIR_SE   = 4'd3;
    localparam logic [DIR_W-1:0] DIR_S    = 4'd4;
    localparam logic [DIR_W-1:0] DIR_SW   = 4'd5;
    localparam logic [DIR_W-1:0] DIR_W_   = 4'd6;
    localparam logic [DIR_W-1:0] DIR_NW   = 4'd7;
    localparam logic [DIR_W-1:0] DIR_STAY = 4'd8;

    typedef enum logic [1:0] {
        OP_CELL  = 2'd0,
        OP_BASE  = 2'd1,
        OP_PLACE = 2'd2,
        OP_MOVE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_COLLISION = 2'd2,
        ST_NO_BASE   = 2'd3
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic              blocked;
        logic [SLOT_W-1:0] base_slot;
        logic [ID_W-1:0]   base_id;
        logic [AG_W-1:0]   agent_index;
        logic [DIR_W-1:0]  direction;
    } t_in_word;

    typedef struct packed {
        logic             feasible;
        t_status          status;
        logic             step_done;
        logic [ROW_W-1:0] agent_row;
        logic [COL_W-1:0] agent_col;
    } t_out_word;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [CNT_W-1:0] agents;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    // signed target with room for one step off either edge
    typedef struct packed {
        logic signed [ROW_W+1:0] row;
        logic signed [COL_W+1:0] col;
    } t_target;

    // item in the execute stage with the position and target formed ahead
    typedef struct packed {
        t_in_word item;
        t_pos     cur;
        t_target  tgt;
    } t_exec_stage;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [OBS_AW-1:0] addr;
        logic              wdata;
    } t_obs_req;

    typedef logic signed [1:0] t_delta;

    localparam t_delta D_NEG  = -2'sd1;
    localparam t_delta D_ZERO = 2'sd0;
    localparam t_delta D_POS  = 2'sd1;

    function automatic t_delta dir_drow(input logic [DIR_W-1:0] dir);
        t_delta d;
        case (dir) inside
            DIR_N, DIR_NE, DIR_NW: d = D_NEG;
            DIR_SE, DIR_S, DIR_SW: d = D_POS;
            default:               d = D_ZERO;
        endcase
        return d;
    endfunction

    function automatic t_delta dir_dcol(input logic [DIR_W-1:0] dir);
        t_delta d;
        case (dir) inside
            DIR_NE, DIR_E, DIR_SE:  d = D_POS;
            DIR_SW, DIR_W_, DIR_NW: d = D_NEG;
            default:                d = D_ZERO;
        endcase
        return d;
    endfunction

    function automatic t_target step_target(input t_pos p, input logic [DIR_W-1:0] dir);
        t_target t;
        t.row = $signed({2'b00, p.row}) + (ROW_W+2)'(dir_drow(dir));
        t.col = $signed({2'b00, p.col}) + (COL_W+2)'(dir_dcol(dir));
        return t;
    endfunction

endpackage

// ----- src/mgrc_obs_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrc_obs_mem
// single-port obstacle flag memory, registered read, cleared by a sweep
// ----------------------------------------------------------------------------
module mgrc_obs_mem
    import mgrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_obs_req i_req,
    output logic     o_rd_data,
    output logic     o_busy
);

    logic              r_mem [MAX_ROWS*MAX_COLS];
    logic              r_rd_data;
    logic              r_busy;
    logic [OBS_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + OBS_AW'(1);
            if (r_clr_addr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ----- src/mgrc_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrc_exec
// execute stage: agent positions, base table, sticky verdict, result word
// ----------------------------------------------------------------------------
module mgrc_exec
    import mgrc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_commit,
    input  t_exec_stage                 i_stage,
    input  logic                        i_blocked,
    output t_pos [MAX_AGENTS-1:0]       o_pos,
    output t_out_word                   o_res
);

    t_pos [MAX_AGENTS-1:0] r_pos;
    t_pos [MAX_AGENTS-1:0] n_pos;
    logic [MAX_BASES-1:0]  r_base_v;
    logic [MAX_BASES-1:0]  n_base_v;
    logic [ID_W-1:0]       r_base_id  [MAX_BASES];
    logic [ID_W-1:0]       n_base_id  [MAX_BASES];
    t_pos                  r_base_pos [MAX_BASES];
    t_pos                  n_base_pos [MAX_BASES];
    logic                  r_route_ok;
    logic                  n_route_ok;

    t_in_word              item;
    t_pos                  hit_pos;
    t_pos                  new_pos;
    t_pos [MAX_AGENTS-1:0] pos_upd;
    logic                  b_found;
    logic                  in_grid;
    logic                  agent_in;
    logic                  closes_step;
    logic                  moving;
    logic                  legal;
    logic                  hit;
    logic                  ok_start;
    t_out_word             res;

    always_comb begin
        item = i_stage.item;

        // lowest matching slot wins
        b_found = 1'b0;
        hit_pos = '0;
        for (int s = MAX_BASES - 1; s >= 0; s--) begin
            if (r_base_v[s] && r_base_id[s] == item.base_id) begin
                b_found = 1'b1;
                hit_pos = r_base_pos[s];
            end
        end

        in_grid = !i_stage.tgt.row[ROW_W+1] && !i_stage.tgt.col[COL_W+1]
                  && (i_stage.tgt.row[ROW_W:0] < i_cfg.rows)
                  && (i_stage.tgt.col[COL_W:0] < i_cfg.cols);
        agent_in    = CNT_W'(item.agent_index) < i_cfg.agents;
        closes_step = CNT_W'(item.agent_index) == i_cfg.agents - CNT_W'(1);
        moving      = item.direction != DIR_STAY;
        legal       = agent_in && (item.direction <= DIR_STAY)
                      && (!moving || (in_grid && !i_blocked));

        new_pos = i_stage.cur;
        if (legal && moving) begin
            new_pos.row = i_stage.tgt.row[ROW_W-1:0];
            new_pos.col = i_stage.tgt.col[COL_W-1:0];
        end

        // pairwise shared-cell test over agents in use
        pos_upd                   = r_pos;
        pos_upd[item.agent_index] = new_pos;
        hit                       = 1'b0;
        for (int i = 0; i < MAX_AGENTS; i++) begin
            for (int j = i + 1; j < MAX_AGENTS; j++) begin
                if (CNT_W'(j) < i_cfg.agents && pos_upd[i] == pos_upd[j]) begin
                    hit = 1'b1;
                end
            end
        end

        ok_start = (item.agent_index == '0) ? 1'b1 : r_route_ok;

        n_pos      = r_pos;
        n_base_v   = r_base_v;
        n_base_id  = r_base_id;
        n_base_pos = r_base_pos;
        n_route_ok = r_route_ok;
        res        = '0;
        res.feasible = r_route_ok;
        res.status   = ST_OK;

        case (item.operation)
            OP_BASE: begin
                if (item.base_slot < MAX_BASES) begin
                    n_base_v[item.base_slot[SLOT_IDX_W-1:0]]       = 1'b1;
                    n_base_id[item.base_slot[SLOT_IDX_W-1:0]]      = item.base_id;
                    n_base_pos[item.base_slot[SLOT_IDX_W-1:0]].row = item.cell_row;
                    n_base_pos[item.base_slot[SLOT_IDX_W-1:0]].col = item.cell_col;
                end
            end
            OP_PLACE: begin
                if (!b_found) begin
                    n_route_ok    = 1'b0;
                    res.feasible  = 1'b0;
                    res.status    = ST_NO_BASE;
                    res.agent_row = i_stage.cur.row;
                    res.agent_col = i_stage.cur.col;
                end else begin
                    n_pos[item.agent_index] = hit_pos;
                    n_route_ok    = ok_start;
                    res.feasible  = ok_start;
                    res.agent_row = hit_pos.row;
                    res.agent_col = hit_pos.col;
                end
            end
            OP_MOVE: begin
                if (!r_route_ok) begin
                    // failed route ignores moves
                    res.feasible  = 1'b0;
                    res.agent_row = i_stage.cur.row;
                    res.agent_col = i_stage.cur.col;
                end else if (!legal) begin
                    n_route_ok    = 1'b0;
                    res.feasible  = 1'b0;
                    res.status    = ST_ILLEGAL;
                    res.step_done = closes_step;
                    res.agent_row = i_stage.cur.row;
                    res.agent_col = i_stage.cur.col;
                end else begin
                    n_pos[item.agent_index] = new_pos;
                    res.step_done = closes_step;
                    res.agent_row = new_pos.row;
                    res.agent_col = new_pos.col;
                    if (closes_step && hit) begin
                        n_route_ok   = 1'b0;
                        res.feasible = 1'b0;
                        res.status   = ST_COLLISION;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_base_v   <= '0;
            r_route_ok <= 1'b1;
        end else if (i_commit) begin
            r_pos      <= n_pos;
            r_base_v   <= n_base_v;
            r_route_ok <= n_route_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_base_id  <= n_base_id;
            r_base_pos <= n_base_pos;
        end
    end

    assign o_pos = r_pos;
    assign o_res = res;

endmodule

// ----- src/multi_agent_grid_route_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_agent_grid_route_checker
// checks a multi-agent route on a grid with obstacles and base positions
// ----------------------------------------------------------------------------
// Three register stages: input word, execute (obstacle read data arrives
// here), result word; a word moves on when the next stage is free, so
// output back-pressure can hold it. One word is taken per cycle while
// nothing stalls. A place or move that directly follows a place or move of
// the same agent waits in the input stage, because the target cell address
// is formed there from the stored position, which the earlier word only
// writes when it leaves the execute stage; with a single agent, a move
// cannot enter execute until the one before has left it. The obstacle flags
// sit in a single-port memory of MAX_ROWS*MAX_COLS bits with a registered
// read. After reset a clearing pass over all 4096 cells frees every cell;
// no word is accepted during that pass, configuration writes are.
// ----------------------------------------------------------------------------
module multi_agent_grid_route_checker
    import mgrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  r_a_v;
    t_in_word              r_a;
    logic                  r_b_v;
    t_exec_stage           r_b;
    logic                  r_o_v;
    t_out_word             r_o;

    logic [DIM_W-1:0]      sat_rows;
    logic [DIM_W-1:0]      sat_cols;
    logic [CNT_W-1:0]      sat_agents;
    t_pos [MAX_AGENTS-1:0] pos;
    t_pos                  pos_a;
    t_target               tgt_a;
    t_obs_req              obs_req;
    logic                  obs_blocked;
    logic                  obs_busy;
    t_out_word             exec_res;
    logic                  hazard;
    logic                  a_adv;
    logic                  b_adv;
    logic                  in_acc;

    // configuration, saturated on write
    always_comb begin
        sat_rows = i_cfg_data;
        if (i_cfg_data == '0) begin
            sat_rows = DIM_W'(1);
        end else if (i_cfg_data > MAX_ROWS) begin
            sat_rows = DIM_W'(MAX_ROWS);
        end
        sat_cols = i_cfg_data;
        if (i_cfg_data == '0) begin
            sat_cols = DIM_W'(1);
        end else if (i_cfg_data > MAX_COLS) begin
            sat_cols = DIM_W'(MAX_COLS);
        end
        sat_agents = i_cfg_data[CNT_W-1:0];
        if (i_cfg_data[CNT_W-1:0] == '0) begin
            sat_agents = CNT_W'(1);
        end else if (i_cfg_data[CNT_W-1:0] > MAX_AGENTS) begin
            sat_agents = CNT_W'(MAX_AGENTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows   <= DIM_W'(MAX_ROWS);
            r_cfg.cols   <= DIM_W'(MAX_COLS);
            r_cfg.agents <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS:   r_cfg.rows   <= sat_rows;
                CFG_GRID_COLS:   r_cfg.cols   <= sat_cols;
                CFG_AGENT_COUNT: r_cfg.agents <= sat_agents;
                default: begin
                end
            endcase
        end
    end

    // input stage: target address for the obstacle read
    assign pos_a = pos[r_a.agent_index];
    assign tgt_a = step_target(pos_a, r_a.direction);

    assign hazard = r_b_v
                    && (r_b.item.operation == OP_PLACE || r_b.item.operation == OP_MOVE)
                    && (r_a.operation == OP_PLACE || r_a.operation == OP_MOVE)
                    && r_b.item.agent_index == r_a.agent_index;

    assign b_adv  = r_b_v && (!r_o_v || i_out_ready);
    assign a_adv  = r_a_v && (!r_b_v || b_adv) && !hazard;
    assign o_in_ready = !obs_busy && (!r_a_v || a_adv);
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        obs_req.wr_en = a_adv && r_a.operation == OP_CELL
                        && r_a.cell_row < MAX_ROWS && r_a.cell_col < MAX_COLS;
        obs_req.rd_en = a_adv && r_a.operation == OP_MOVE;
        obs_req.wdata = r_a.blocked;
        if (r_a.operation == OP_CELL) begin
            obs_req.addr = {r_a.cell_row, r_a.cell_col};
        end else begin
            obs_req.addr = {tgt_a.row[ROW_W-1:0], tgt_a.col[COL_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_v <= 1'b1;
            end else if (a_adv) begin
                r_a_v <= 1'b0;
            end
            if (a_adv) begin
                r_b_v <= 1'b1;
            end else if (b_adv) begin
                r_b_v <= 1'b0;
            end
            if (b_adv) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a <= i_in_word;
        end
        if (a_adv) begin
            r_b.item <= r_a;
            r_b.cur  <= pos_a;
            r_b.tgt  <= tgt_a;
        end
        if (b_adv) begin
            r_o <= exec_res;
        end
    end

    mgrc_obs_mem u_obs_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (obs_req),
        .o_rd_data (obs_blocked),
        .o_busy    (obs_busy)
    );

    mgrc_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_commit  (b_adv),
        .i_stage   (r_b),
        .i_blocked (obs_blocked),
        .o_pos     (pos),
        .o_res     (exec_res)
    );

    assign o_out_valid = r_o_v;
    assign o_out_word  = r_o;

endmodule

// ----- src/mgrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrc_checker
// port-level checks of the grid route checker, bound to the top level
// ----------------------------------------------------------------------------
module mgrc_checker
    import mgrc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // any failure status reports an infeasible route
    a_fail_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> !o_out_word.feasible)
        else $error("failure status with feasible set");

    // collisions are only found when a time step closes
    a_collision_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_COLLISION |-> o_out_word.step_done)
        else $error("collision without closed step");

    // obstacle clearing keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("word accepted during obstacle clearing");

endmodule

bind multi_agent_grid_route_checker mgrc_checker u_mgrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
